// File: rtl/core/fir_filter_circular_buffer_assert.svh
// Assertion macros shared by the FIR filter modules.
`ifndef FIR_FILTER_CIRCULAR_BUFFER_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FIR_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define FIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/fircb_pkg.sv
// Shared types and constants of the circular-buffer FIR filter.
package fircb_pkg;

    localparam int DATA_W    = 16;
    localparam int PROD_W    = 32;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 8;
    localparam int CIDX_W    = 7;
    localparam int FRAC_BITS = 15;

    localparam logic MODE_COEFF  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Sequencer to datapath.
    typedef struct packed {
        logic clear;
        logic issue;
        logic load;
    } t_mac_ctl;

    // Datapath to sequencer.
    typedef struct packed {
        logic busy;
        logic out_free;
    } t_mac_sts;

endpackage

// File: rtl/core/fir_filter_circular_buffer.sv
// Top level of the circular-buffer direct-form FIR filter.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_mode, i_coeff_index, i_coeff_value,
//                                                 i_sample, i_last_sample
//  output    out        o_out_valid / i_out_stall o_filtered, o_last
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_data (tap_count)
//
// An in-range coefficient goes into its memory as it is taken. For a sample transfer, where taps
// is tap_count with zero taken as one and counts above MAX_TAPS taken as MAX_TAPS:
// one shared multiplier walks the taps at one per cycle, fed from the two memories,
// followed by a drain through the product register and accumulator and then the result load.
// After reset a clearing pass zeroes both memories; no input is taken during that time.
// A stalled output holds its result and the next item may still be taken, but its result
// waits until the output register is free.
module fir_filter_circular_buffer #(
    parameter int MAX_TAPS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [fircb_pkg::CIDX_W-1:0]        i_coeff_index,
    input  logic signed [fircb_pkg::DATA_W-1:0] i_coeff_value,
    input  logic signed [fircb_pkg::DATA_W-1:0] i_sample,
    input  logic                                i_last_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [fircb_pkg::OUT_W-1:0]  o_filtered,
    output logic                                o_last,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fircb_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int AW = $clog2(MAX_TAPS);

    fircb_pkg::t_mac_ctl           mac_ctl;
    fircb_pkg::t_mac_sts           mac_sts;
    logic                          coef_we;
    logic [AW-1:0]                 coef_waddr;
    logic [fircb_pkg::DATA_W-1:0]  coef_wdata;
    logic                          dly_we;
    logic [AW-1:0]                 dly_waddr;
    logic [fircb_pkg::DATA_W-1:0]  dly_wdata;
    logic                          rd_en;
    logic [AW-1:0]                 coef_raddr;
    logic [AW-1:0]                 dly_raddr;
    logic [fircb_pkg::DATA_W-1:0]  coef_rdata;
    logic [fircb_pkg::DATA_W-1:0]  dly_rdata;

    fircb_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_sample      (i_sample),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_sts         (mac_sts),
        .o_ctl         (mac_ctl),
        .o_coef_we     (coef_we),
        .o_coef_waddr  (coef_waddr),
        .o_coef_wdata  (coef_wdata),
        .o_dly_we      (dly_we),
        .o_dly_waddr   (dly_waddr),
        .o_dly_wdata   (dly_wdata),
        .o_rd_en       (rd_en),
        .o_coef_raddr  (coef_raddr),
        .o_dly_raddr   (dly_raddr)
    );

    fircb_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (fircb_pkg::DATA_W)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (coef_wdata),
        .i_re    (rd_en),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    fircb_ram #(
        .DEPTH (MAX_TAPS),
        .WIDTH (fircb_pkg::DATA_W)
    ) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (dly_we),
        .i_waddr (dly_waddr),
        .i_wdata (dly_wdata),
        .i_re    (rd_en),
        .i_raddr (dly_raddr),
        .o_rdata (dly_rdata)
    );

    fircb_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mac_ctl),
        .i_last      (i_last_sample),
        .i_coef      (signed'(coef_rdata)),
        .i_dly       (signed'(dly_rdata)),
        .i_out_stall (i_out_stall),
        .o_sts       (mac_sts),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered),
        .o_last      (o_last)
    );

endmodule

// File: rtl/core/fircb_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fircb_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/fircb_mac.sv
// Multiply-accumulate datapath, output scaling with saturation and the result register.
`include "fir_filter_circular_buffer_assert.svh"
module fircb_mac #(
    parameter int MAX_TAPS = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fircb_pkg::t_mac_ctl                    i_ctl,
    input  logic                                   i_last,
    input  logic signed [fircb_pkg::DATA_W-1:0]    i_coef,
    input  logic signed [fircb_pkg::DATA_W-1:0]    i_dly,
    input  logic                                   i_out_stall,
    output fircb_pkg::t_mac_sts                    o_sts,
    output logic                                   o_out_valid,
    output logic signed [fircb_pkg::OUT_W-1:0]     o_filtered,
    output logic                                   o_last
);

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int ACC_W = fircb_pkg::PROD_W + AW;
    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    logic                                r_dvld;
    logic                                r_prod_vld;
    logic signed [fircb_pkg::PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]             r_acc;
    logic                                r_last_hold;
    logic                                r_out_valid;
    logic signed [fircb_pkg::OUT_W-1:0]  r_filtered;
    logic                                r_last_out;

    logic signed [63:0]                  acc_ext;
    logic signed [63:0]                  q;
    logic signed [fircb_pkg::OUT_W-1:0]  n_filtered;

    // Read data arrives in the cycle after the address goes out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld     <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_dvld     <= i_ctl.issue;
            r_prod_vld <= r_dvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dvld) begin
            r_prod <= i_coef * i_dly;
        end
        if (i_ctl.clear) begin
            r_acc       <= '0;
            r_last_hold <= i_last;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // The arithmetic shift gives floor rounding.
    always_comb begin
        acc_ext = 64'(r_acc);
        q       = acc_ext >>> fircb_pkg::FRAC_BITS;
        if (q > Q_MAX) begin
            n_filtered = Q_MAX[fircb_pkg::OUT_W-1:0];
        end else if (q < Q_MIN) begin
            n_filtered = Q_MIN[fircb_pkg::OUT_W-1:0];
        end else begin
            n_filtered = q[fircb_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_filtered <= n_filtered;
            r_last_out <= r_last_hold;
        end
    end

    assign o_sts.busy     = r_dvld | r_prod_vld;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_filtered     = r_filtered;
    assign o_last         = r_last_out;

    `FIR_ASSERT_SAME(a_load_after_drain, i_clk, i_rst_n, i_ctl.load, !r_dvld && !r_prod_vld)
    `FIR_ASSERT_SAME(a_load_slot_free, i_clk, i_rst_n, i_ctl.load, !r_out_valid || !i_out_stall)
    `FIR_ASSERT_SAME(a_prod_follows_data, i_clk, i_rst_n, r_prod_vld, $past(r_dvld))

endmodule

// File: rtl/core/fircb_ctrl.sv
// Sequencer: tap-count register, clearing pass, item intake, tap address generation and drain.
`include "fir_filter_circular_buffer_assert.svh"
module fircb_ctrl #(
    parameter int MAX_TAPS = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_mode,
    input  logic [fircb_pkg::CIDX_W-1:0]          i_coeff_index,
    input  logic [fircb_pkg::DATA_W-1:0]          i_coeff_value,
    input  logic [fircb_pkg::DATA_W-1:0]          i_sample,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fircb_pkg::CFG_W-1:0]           i_cfg_data,
    input  fircb_pkg::t_mac_sts                   i_sts,
    output fircb_pkg::t_mac_ctl                   o_ctl,
    output logic                                  o_coef_we,
    output logic [$clog2(MAX_TAPS)-1:0]           o_coef_waddr,
    output logic [fircb_pkg::DATA_W-1:0]          o_coef_wdata,
    output logic                                  o_dly_we,
    output logic [$clog2(MAX_TAPS)-1:0]           o_dly_waddr,
    output logic [fircb_pkg::DATA_W-1:0]          o_dly_wdata,
    output logic                                  o_rd_en,
    output logic [$clog2(MAX_TAPS)-1:0]           o_coef_raddr,
    output logic [$clog2(MAX_TAPS)-1:0]           o_dly_raddr
);

    localparam int AW = $clog2(MAX_TAPS);
    localparam int TW = AW + 1;
    localparam int CW = (TW > fircb_pkg::CFG_W) ? TW : fircb_pkg::CFG_W;

    fircb_pkg::t_state             r_state, n_state;
    logic [AW-1:0]                 r_clr, n_clr;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [AW-1:0]                 r_base, n_base;
    logic [TW-1:0]                 r_tap, n_tap;
    logic [TW-1:0]                 r_taps, n_taps;
    logic [fircb_pkg::CFG_W-1:0]   r_tap_count;

    logic                          accept;
    logic [CW-1:0]                 cnt_w;
    logic [TW-1:0]                 taps_clamped;
    logic                          coef_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fircb_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_tap_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cnt_w = CW'(r_tap_count);
        if (cnt_w == '0) begin
            taps_clamped = TW'(1);
        end else if (cnt_w > CW'(MAX_TAPS)) begin
            taps_clamped = TW'(MAX_TAPS);
        end else begin
            taps_clamped = cnt_w[TW-1:0];
        end
    end

    assign coef_in_range = CW'(i_coeff_index) < CW'(MAX_TAPS);
    assign o_in_stall    = (r_state != fircb_pkg::ST_IDLE);
    assign accept        = i_in_valid && (r_state == fircb_pkg::ST_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_pos        = r_pos;
        n_base       = r_base;
        n_tap        = r_tap;
        n_taps       = r_taps;
        o_ctl        = '0;
        o_coef_we    = 1'b0;
        o_coef_waddr = AW'(i_coeff_index);
        o_coef_wdata = i_coeff_value;
        o_dly_we     = 1'b0;
        o_dly_waddr  = r_pos;
        o_dly_wdata  = i_sample;
        o_rd_en      = 1'b0;
        o_coef_raddr = r_tap[AW-1:0];
        o_dly_raddr  = r_base - r_tap[AW-1:0];
        case (r_state)
            fircb_pkg::ST_CLEAR: begin
                // Both memories are zeroed one entry per cycle after reset.
                o_coef_we    = 1'b1;
                o_coef_waddr = r_clr;
                o_coef_wdata = '0;
                o_dly_we     = 1'b1;
                o_dly_waddr  = r_clr;
                o_dly_wdata  = '0;
                n_clr        = r_clr + AW'(1);
                if (r_clr == '1) begin
                    n_state = fircb_pkg::ST_IDLE;
                end
            end
            fircb_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_mode == fircb_pkg::MODE_SAMPLE) begin
                        o_dly_we    = 1'b1;
                        o_ctl.clear = 1'b1;
                        n_base      = r_pos;
                        n_pos       = r_pos + AW'(1);
                        n_tap       = '0;
                        n_taps      = taps_clamped;
                        n_state     = fircb_pkg::ST_RUN;
                    end else begin
                        o_coef_we = coef_in_range;
                    end
                end
            end
            fircb_pkg::ST_RUN: begin
                o_rd_en     = 1'b1;
                o_ctl.issue = 1'b1;
                n_tap       = r_tap + TW'(1);
                if (r_tap == r_taps - TW'(1)) begin
                    n_state = fircb_pkg::ST_DRAIN;
                end
            end
            fircb_pkg::ST_DRAIN: begin
                if (!i_sts.busy && i_sts.out_free) begin
                    o_ctl.load = 1'b1;
                    n_state    = fircb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fircb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fircb_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_tap  <= n_tap;
        r_taps <= n_taps;
    end

    `FIR_ASSERT_NEXT(a_sample_starts_run, i_clk, i_rst_n,
        accept && (i_mode == fircb_pkg::MODE_SAMPLE), r_state == fircb_pkg::ST_RUN)
    `FIR_ASSERT_SAME(a_tap_in_range, i_clk, i_rst_n,
        r_state == fircb_pkg::ST_RUN, (r_tap < r_taps) && (r_taps != '0))
    `FIR_ASSERT_SAME(a_no_write_during_read, i_clk, i_rst_n, o_rd_en, !o_coef_we && !o_dly_we)

endmodule
